// ----- sv/mailbox_message_deframer_assert.svh -----
// Assertion macros used by the mailbox message deframer top level.
`ifndef MAILBOX_MESSAGE_DEFRAMER_ASSERT_SVH
`define MAILBOX_MESSAGE_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MMD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/mmd_pkg.sv -----
// Package: types and constants of the mailbox message deframer.
package mmd_pkg;

    localparam int NUM_SLOTS  = 8;
    localparam int LEN_W      = 9;
    localparam int SLOT_W     = 3;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [LEN_W-1:0] MAX_LEN   = 9'd511;
    localparam logic [7:0]       ADDR_BIAS = 8'd5;

    // Result item kinds
    typedef enum logic [1:0] {
        KIND_HDR_ACCEPT  = 2'd0,
        KIND_HDR_DROP    = 2'd1,
        KIND_PAY_KEEP    = 2'd2,
        KIND_PAY_DISCARD = 2'd3
    } t_kind;

    // Classified beat handed from the front end to the back end
    typedef struct packed {
        t_kind              kind;
        logic [SLOT_W-1:0]  slot;
        logic [7:0]         remote;
        logic [LEN_W-1:0]   length;
        logic [31:0]        payload;
        logic [2:0]         count;
        logic [LEN_W-1:0]   offset;
        logic               msg_end;
        logic               keep;
        logic               complete;
        logic [LEN_W-1:0]   position;
    } t_cmd;

    // Finished result item
    typedef struct packed {
        t_kind              kind;
        logic [SLOT_W-1:0]  slot;
        logic [7:0]         remote;
        logic [LEN_W-1:0]   length;
        logic [31:0]        payload;
        logic [2:0]         count;
        logic [LEN_W-1:0]   offset;
        logic               msg_end;
        logic               done;
        logic [LEN_W-1:0]   total;
    } t_result;

endpackage

// ----- sv/mmd_front.sv -----
// Front end: header/payload framing and classification of each mailbox beat.
module mmd_front
    import mmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [31:0] i_dword,
    input  logic [7:0]  i_mask,
    output t_cmd        o_cmd
);

    logic                r_in_msg, n_in_msg;
    logic                r_drop, n_drop;
    logic [LEN_W-1:0]    r_left, n_left;
    logic [LEN_W-1:0]    r_pos, n_pos;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [7:0]          r_remote, n_remote;
    logic [LEN_W-1:0]    r_len, n_len;
    logic                r_complete, n_complete;

    logic [7:0]          slot8;
    logic [LEN_W-1:0]    hdr_len;
    logic                active;
    logic [2:0]          nbytes;
    logic [31:0]         payload;

    // Header decode
    always_comb begin
        hdr_len = i_dword[24:16];
        if (hdr_len > MAX_LEN) begin
            hdr_len = MAX_LEN;
        end
        slot8  = i_dword[15:8] - ADDR_BIAS;
        active = (slot8 < 8'(NUM_SLOTS)) && (slot8 < 8'd8) && i_mask[slot8[2:0]];
    end

    // Payload lane selection
    always_comb begin
        nbytes = (r_left < 9'd4) ? r_left[2:0] : 3'd4;
        unique case (nbytes)
            3'd0:    payload = 32'd0;
            3'd1:    payload = {24'd0, i_dword[7:0]};
            3'd2:    payload = {16'd0, i_dword[15:0]};
            3'd3:    payload = {8'd0, i_dword[23:0]};
            default: payload = i_dword;
        endcase
    end

    // Next framing state and classified beat
    always_comb begin
        n_in_msg   = r_in_msg;
        n_drop     = r_drop;
        n_left     = r_left;
        n_pos      = r_pos;
        n_slot     = r_slot;
        n_remote   = r_remote;
        n_len      = r_len;
        n_complete = r_complete;
        o_cmd      = '0;
        if (!r_in_msg) begin
            n_remote   = i_dword[7:0];
            n_len      = hdr_len;
            n_complete = i_dword[31];
            n_left     = hdr_len;
            n_pos      = '0;
            n_drop     = !active;
            n_slot     = slot8[SLOT_W-1:0];
            o_cmd.kind = active ? KIND_HDR_ACCEPT : KIND_HDR_DROP;
        end else begin
            n_left       = r_left - LEN_W'(nbytes);
            n_pos        = r_pos + LEN_W'(nbytes);
            o_cmd.kind   = r_drop ? KIND_PAY_DISCARD : KIND_PAY_KEEP;
            o_cmd.payload = payload;
            o_cmd.count  = nbytes;
            o_cmd.offset = r_pos;
        end
        o_cmd.slot     = n_slot;
        o_cmd.remote   = n_remote;
        o_cmd.length   = n_len;
        o_cmd.keep     = !n_drop;
        o_cmd.complete = n_complete;
        o_cmd.position = n_pos;
        o_cmd.msg_end  = (n_left == '0);
        n_in_msg       = (n_left != '0);
        if (n_left == '0) begin
            n_drop = 1'b0;
        end
    end

    // Framing state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg   <= 1'b0;
            r_drop     <= 1'b0;
            r_left     <= '0;
            r_pos      <= '0;
            r_slot     <= '0;
            r_remote   <= '0;
            r_len      <= '0;
            r_complete <= 1'b0;
        end else if (i_accept) begin
            r_in_msg   <= n_in_msg;
            r_drop     <= n_drop;
            r_left     <= n_left;
            r_pos      <= n_pos;
            r_slot     <= n_slot;
            r_remote   <= n_remote;
            r_len      <= n_len;
            r_complete <= n_complete;
        end
    end

endmodule

// ----- sv/mmd_queue.sv -----
// Short queue of classified beats between front end and back end.
module mmd_queue
    import mmd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_data
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- sv/mmd_back.sv -----
// Back end: per-slot transfer totals, completion and the result register.
module mmd_back
    import mmd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_cmd    i_cmd,
    output logic    o_q_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_res
);

    logic [LEN_W-1:0] r_totals [NUM_SLOTS];
    logic             r_valid;
    t_result          r_res;
    t_result          n_res;
    logic [LEN_W:0]   sum;
    logic [LEN_W-1:0] sat;
    logic             upd;

    assign o_q_pop = !i_q_empty && (!r_valid || i_pop);
    assign o_empty = !r_valid;
    assign o_res   = r_res;
    assign upd     = o_q_pop && i_cmd.msg_end && i_cmd.keep;

    // Total update with saturation
    always_comb begin
        sum = {1'b0, r_totals[i_cmd.slot]} + {1'b0, i_cmd.position};
        sat = (sum > {1'b0, MAX_LEN}) ? MAX_LEN : sum[LEN_W-1:0];
    end

    // Result assembly
    always_comb begin
        n_res         = '0;
        n_res.kind    = i_cmd.kind;
        n_res.slot    = i_cmd.slot;
        n_res.remote  = i_cmd.remote;
        n_res.length  = i_cmd.length;
        n_res.payload = i_cmd.payload;
        n_res.count   = i_cmd.count;
        n_res.offset  = i_cmd.offset;
        n_res.msg_end = i_cmd.msg_end;
        if (i_cmd.msg_end && i_cmd.keep) begin
            n_res.total = sat;
            n_res.done  = i_cmd.complete;
        end
    end

    // Slot totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_totals[s] <= '0;
            end
        end else if (upd) begin
            r_totals[i_cmd.slot] <= i_cmd.complete ? '0 : sat;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_res <= n_res;
        end
    end

endmodule

// ----- sv/mailbox_message_deframer.sv -----
// Top level of the mailbox message deframer.
// Takes one mailbox dword per cycle (push/full) and gives one result item per
// dword (empty/pop), in order. A dword outside a message is a header; the
// following dwords carry up to four payload bytes each until the header's length
// is used up. At the end of a kept message the slot's running total is updated
// and reported; with the complete flag it is also marked done and cleared.
// Throughput is one dword per clock while not full. From push to the result ports
// a dword passes through the two-entry queue between the framing front end and
// the back end, then through the result register that holds the slot-total update.
// The active-slot mask is written through the cfg channel, which is always ready.
`include "mailbox_message_deframer_assert.svh"
module mailbox_message_deframer
    import mmd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [31:0]       i_mailbox_dword,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [1:0]        o_item_kind,
    output logic [2:0]        o_slot_index,
    output logic [7:0]        o_remote_address,
    output logic [8:0]        o_message_length,
    output logic [31:0]       o_payload_word,
    output logic [2:0]        o_byte_count,
    output logic [8:0]        o_byte_offset,
    output logic              o_message_end,
    output logic              o_transfer_done,
    output logic [8:0]        o_transfer_total,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [7:0]        i_cfg_data
);

    logic [7:0] r_mask;
    t_cmd       front_cmd;
    t_cmd       q_cmd;
    logic       q_empty;
    logic       q_pop;
    logic       accept;
    t_result    res;

    // Active-slot mask register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mask <= i_cfg_data;
        end
    end

    assign accept = i_push && !o_full;

    mmd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_dword  (i_mailbox_dword),
        .i_mask   (r_mask),
        .o_cmd    (front_cmd)
    );

    mmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (front_cmd),
        .o_full  (o_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_cmd)
    );

    mmd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (q_cmd),
        .o_q_pop   (q_pop),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_res     (res)
    );

    // Result fields
    assign o_item_kind      = res.kind;
    assign o_slot_index     = res.slot;
    assign o_remote_address = res.remote;
    assign o_message_length = res.length;
    assign o_payload_word   = res.payload;
    assign o_byte_count     = res.count;
    assign o_byte_offset    = res.offset;
    assign o_message_end    = res.msg_end;
    assign o_transfer_done  = res.done;
    assign o_transfer_total = res.total;

    // Checks
    `MMD_ASSERT_NOW(a_done_at_end, !o_empty && o_transfer_done, o_message_end,
        "transfer_done without message_end")
    `MMD_ASSERT_NOW(a_drop_no_total,
        !o_empty && (o_item_kind == KIND_HDR_DROP || o_item_kind == KIND_PAY_DISCARD),
        !o_transfer_done && o_transfer_total == '0,
        "dropped message reports a transfer")
    `MMD_ASSERT_NOW(a_hdr_no_bytes,
        !o_empty && (o_item_kind == KIND_HDR_ACCEPT || o_item_kind == KIND_HDR_DROP),
        o_byte_count == '0 && o_payload_word == '0 && o_byte_offset == '0,
        "header result carries payload")
    `MMD_ASSERT_NEXT(a_result_follows, !q_empty && o_empty, !o_empty,
        "queued beat not moved to the result register")

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the mailbox message deframer: directed and random dwords.
module tb_top;
    import mmd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 40;

    // Expected result beat
    typedef struct packed {
        t_kind       kind;
        logic [2:0]  slot;
        logic [7:0]  remote;
        logic [8:0]  length;
        logic [31:0] payload;
        logic [2:0]  count;
        logic [8:0]  offset;
        logic        msg_end;
        logic        done;
        logic [8:0]  total;
    } t_deframed_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_push;
    logic        o_full;
    logic [31:0] i_mailbox_dword;
    logic        o_empty;
    logic        i_pop;
    logic [1:0]  o_item_kind;
    logic [2:0]  o_slot_index;
    logic [7:0]  o_remote_address;
    logic [8:0]  o_message_length;
    logic [31:0] o_payload_word;
    logic [2:0]  o_byte_count;
    logic [8:0]  o_byte_offset;
    logic        o_message_end;
    logic        o_transfer_done;
    logic [8:0]  o_transfer_total;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;

    // Deframer model state
    logic [7:0]  active_mask_model = '0;
    logic        msg_open = 1'b0;
    logic        msg_dropping = 1'b0;
    logic [8:0]  bytes_remaining = '0;
    logic [8:0]  byte_pos = '0;
    logic [2:0]  msg_slot = '0;
    logic [7:0]  msg_remote = '0;
    logic [8:0]  msg_length = '0;
    logic        msg_complete = 1'b0;
    logic [8:0]  slot_total [NUM_SLOTS] = '{default: '0};

    t_deframed_beat pending_results [$];
    int error_count = 0;
    int beat_count = 0;
    int cycle_count;
    int words_left = 0;     // dwords still owed to the message being sent
    int push_mode = 1;
    int push_items = 0;

    mailbox_message_deframer DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_mailbox_dword  (i_mailbox_dword),
        .o_empty          (o_empty),
        .i_pop            (i_pop),
        .o_item_kind      (o_item_kind),
        .o_slot_index     (o_slot_index),
        .o_remote_address (o_remote_address),
        .o_message_length (o_message_length),
        .o_payload_word   (o_payload_word),
        .o_byte_count     (o_byte_count),
        .o_byte_offset    (o_byte_offset),
        .o_message_end    (o_message_end),
        .o_transfer_done  (o_transfer_done),
        .o_transfer_total (o_transfer_total),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predict the beat one accepted dword produces and advance the model
    function automatic t_deframed_beat deframe_dword(logic [31:0] d);
        t_deframed_beat r;
        logic [7:0] slot8;
        logic [8:0] len;
        int n;
        int sum;
        r = '0;
        if (!msg_open) begin
            len = d[24:16];
            if (len > MAX_LEN) len = MAX_LEN;
            slot8 = d[15:8] - ADDR_BIAS;
            msg_remote = d[7:0];
            msg_length = len;
            msg_complete = d[31];
            bytes_remaining = len;
            byte_pos = '0;
            msg_dropping = !(slot8 < NUM_SLOTS && active_mask_model[slot8[2:0]]);
            msg_slot = slot8[2:0];
            msg_open = 1'b1;
            r.kind = msg_dropping ? KIND_HDR_DROP : KIND_HDR_ACCEPT;
        end else begin
            n = (bytes_remaining < 4) ? int'(bytes_remaining) : 4;
            r.kind = msg_dropping ? KIND_PAY_DISCARD : KIND_PAY_KEEP;
            r.payload = (n == 4) ? d : d & ((32'd1 << (8 * n)) - 32'd1);
            r.count = 3'(n);
            r.offset = byte_pos;
            byte_pos = byte_pos + 9'(n);
            bytes_remaining = bytes_remaining - 9'(n);
        end
        r.slot = msg_slot;
        r.remote = msg_remote;
        r.length = msg_length;
        // message end: kept slots accumulate and may complete
        if (bytes_remaining == 0) begin
            r.msg_end = 1'b1;
            if (!msg_dropping) begin
                sum = int'(slot_total[msg_slot]) + int'(byte_pos);
                if (sum > int'(MAX_LEN)) sum = int'(MAX_LEN);
                slot_total[msg_slot] = 9'(sum);
                r.total = 9'(sum);
                if (msg_complete) begin
                    r.done = 1'b1;
                    slot_total[msg_slot] = '0;
                end
            end
            msg_open = 1'b0;
            msg_dropping = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (error_count < PRINT_LIMIT) $display("MISMATCH: %s", msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("beat %0d %s: got 0x%0h, expected 0x%0h",
                                      beat_count, name, got, want));
    endtask

    // Monitor: config writes, accepted dwords, accepted result beats
    always @(posedge i_clk) begin
        t_deframed_beat want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) active_mask_model = i_cfg_data;
            if (i_push && !o_full) pending_results.push_back(deframe_dword(i_mailbox_dword));
            if (i_pop && !o_empty) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("beat %0d arrived with no dword pending",
                                              beat_count));
                end else begin
                    want = pending_results.pop_front();
                    check_field("item_kind", o_item_kind, want.kind);
                    check_field("slot_index", o_slot_index, want.slot);
                    check_field("remote_address", o_remote_address, want.remote);
                    check_field("message_length", o_message_length, want.length);
                    check_field("payload_word", o_payload_word, want.payload);
                    check_field("byte_count", o_byte_count, want.count);
                    check_field("byte_offset", o_byte_offset, want.offset);
                    check_field("message_end", o_message_end, want.msg_end);
                    check_field("transfer_done", o_transfer_done, want.done);
                    check_field("transfer_total", o_transfer_total, want.total);
                end
                beat_count++;
            end
        end
    end

    // Idle cycles before a beat: none, any, or occasional
    function automatic int draw_wait(int mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 13);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
        endcase
    endfunction

    // Result side: pop with random stalls
    initial begin
        int pop_mode;
        int pop_items;
        pop_mode = 1;
        pop_items = 0;
        i_pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (pop_items % 64 == 0) pop_mode = $urandom_range(0, 2);
            pop_items++;
            repeat (draw_wait(pop_mode)) begin
                @(negedge i_clk) i_pop <= 1'b0;
            end
            @(negedge i_clk) i_pop <= 1'b1;
            do @(posedge i_clk); while (o_empty);
        end
    end

    task automatic send_dword(logic [31:0] d);
        if (push_items % 64 == 0) push_mode = $urandom_range(0, 2);
        push_items++;
        repeat (draw_wait(push_mode)) begin
            @(negedge i_clk) i_push <= 1'b0;
        end
        @(negedge i_clk);
        i_push <= 1'b1;
        i_mailbox_dword <= d;
        do @(posedge i_clk); while (o_full);
    endtask

    task automatic send_raw_header(logic [31:0] d);
        words_left = (int'(d[24:16]) + 3) / 4;
        send_dword(d);
    endtask

    // Header with random unused bits 30:25
    task automatic send_header(logic [7:0] host, logic [8:0] len, logic [7:0] remote,
                               logic complete);
        logic [5:0] junk;
        junk = 6'($urandom);
        send_raw_header({complete, junk, len, host, remote});
    endtask

    task automatic send_payload(logic [31:0] d);
        words_left--;
        send_dword(d);
    endtask

    // Stop pushing and let every expected beat come out
    task automatic wait_idle();
        @(negedge i_clk) i_push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_mask(logic [7:0] m);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        write_mask(8'hFF);
        // zero length on slot 0, completes at the header with total 0
        send_header(8'd5, 9'd0, 8'h00, 1'b1);
        // slot 7, length 5 over two dwords, last one partial
        send_header(8'd12, 9'd5, 8'hFF, 1'b0);
        send_payload(32'hFFFF_FFFF);
        send_payload(32'hFFFF_FFFF);
        // same slot completes with the running total
        send_header(8'd12, 9'd3, 8'hA5, 1'b1);
        send_payload($urandom);
        // host below the bias wraps to a slot out of range
        send_header(8'd4, 9'd4, 8'h3C, 1'b1);
        send_payload($urandom);
        // slot 8 is out of range
        send_header(8'd13, 9'd0, 8'h81, 1'b1);
        // all-zero dword and the top host address
        send_raw_header(32'h0000_0000);
        send_header(8'hFF, 9'd1, 8'h7E, 1'b1);
        send_payload(32'h0000_0000);
        // unused header bits all set
        send_raw_header(32'h7E02_0600);
        send_payload($urandom);
        // inactive slot
        wait_idle();
        write_mask(8'h00);
        send_header(8'd8, 9'd2, 8'h11, 1'b1);
        send_payload($urandom);
        wait_idle();
    endtask

    // Running total saturates at the maximum, then clears on completion
    task automatic test_saturation();
        write_mask(8'hFF);
        send_header(8'd9, MAX_LEN, 8'h44, 1'b0);
        while (words_left > 0) send_payload($urandom);
        send_header(8'd9, 9'd1, 8'h44, 1'b1);
        send_payload($urandom);
        send_header(8'd9, 9'd2, 8'h44, 1'b1);
        send_payload($urandom);
        wait_idle();
    endtask

    // The keep/drop decision taken at the header holds across a mask write
    task automatic test_mask_mid_message();
        write_mask(8'h04);
        send_header(8'd7, 9'd8, 8'h5A, 1'b1);
        send_payload($urandom);
        wait_idle();
        write_mask(8'h00);
        send_payload($urandom);
        send_header(8'd7, 9'd4, 8'hC3, 1'b1);
        wait_idle();
        write_mask(8'hFF);
        send_payload($urandom);
        wait_idle();
    endtask

    // Mostly well-formed messages with random content, a little raw noise
    task automatic send_random_item();
        logic [7:0] host;
        logic [8:0] len;
        int pick;
        if (words_left > 0) begin
            send_payload($urandom);
        end else if ($urandom_range(0, 39) == 0) begin
            send_raw_header($urandom);
        end else begin
            host = ($urandom_range(0, 6) == 0) ? 8'($urandom) : 8'($urandom_range(5, 12));
            pick = $urandom_range(0, 19);
            if (pick < 14)      len = 9'($urandom_range(0, 16));
            else if (pick < 19) len = 9'($urandom_range(17, 64));
            else                len = 9'($urandom_range(65, 511));
            send_header(host, len, 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_random(int n);
        int sent;
        int phase;
        sent = 0;
        phase = 0;
        while (sent < n) begin
            // phases may end mid-message, so mask writes land there too
            wait_idle();
            case (phase % 4)
                0: write_mask(8'h00);
                1: write_mask(8'hFF);
                default: write_mask(8'($urandom));
            endcase
            repeat ($urandom_range(50, 200)) begin
                send_random_item();
                sent++;
            end
            phase++;
        end
        wait_idle();
    endtask

    // Run limit
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge i_clk);
        $display("[mailbox_message_deframer] ERROR");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_mailbox_dword = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        test_directed();
        test_saturation();
        test_mask_mid_message();
        test_random(1700);
        if (error_count == 0)
            $display("[mailbox_message_deframer] OK");
        else
            $display("[mailbox_message_deframer] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/mmd_pkg.sv
sv/mmd_front.sv
sv/mmd_queue.sv
sv/mmd_back.sv
sv/mailbox_message_deframer.sv
tb/tb_top.sv
